[design/assert_macros.svh]
// Assertion helpers for the receive ring buffer.
// Both macros expect a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define RRB_ASSERT_NEVER(lbl, expr, msg) \
  `RRB_ASSERT(lbl, !(expr), msg)

`endif

[design/rrb_pkg.sv]
`timescale 1ns / 1ps

package rrb_pkg;

  // Ring depth, a power of two; pointers carry one extra lap bit
  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PTR_W   = ADDR_W + 1;
  localparam int FIELD_W = 11;
  localparam int CMP_W   = (PTR_W > FIELD_W) ? PTR_W : FIELD_W;

  localparam logic [7:0] XOFF_CHAR = 8'h13;
  localparam logic [7:0] XON_CHAR  = 8'h11;

  localparam logic [FIELD_W-1:0] STOP_RESET   = FIELD_W'(128);
  localparam logic [FIELD_W-1:0] RESUME_RESET = FIELD_W'(256);

  // Configuration register indexes
  localparam logic [1:0] CFG_FLOW_ENABLE = 2'd0;
  localparam logic [1:0] CFG_STOP_BELOW  = 2'd1;
  localparam logic [1:0] CFG_RESUME_ABOVE = 2'd2;

  // Item functions
  localparam logic FUNC_RECEIVE = 1'b0;
  localparam logic FUNC_READ    = 1'b1;

  typedef struct packed {
    logic               flow_enable;
    logic [FIELD_W-1:0] stop_free_below;
    logic [FIELD_W-1:0] resume_free_above;
  } rrb_cfg_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } rrb_mem_req_t;

  typedef struct packed {
    logic             read_valid;
    logic             ctrl_valid;
    logic [7:0]       ctrl_byte;
    logic             overflow;
    logic [CMP_W-1:0] fill;
    logic             stopped;
  } rrb_result_t;

endpackage

[design/rrb_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port
module rrb_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/rrb_ctrl.sv]
`timescale 1ns / 1ps

// Head/tail pointers, XON/XOFF decision and buffer access requests
module rrb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 func,
  input  logic [7:0]           rx_byte,
  input  rrb_pkg::rrb_cfg_t    cfg,
  output rrb_pkg::rrb_mem_req_t mem_req,
  output rrb_pkg::rrb_result_t result
);

  // pointer = {lap, index}
  logic [rrb_pkg::PTR_W-1:0] head, head_next;
  logic [rrb_pkg::PTR_W-1:0] tail, tail_next;
  logic                      held, held_next;

  logic                      laps_differ, empty, full, laps_differ_next;
  logic [rrb_pkg::PTR_W-1:0] fill_next;
  logic [rrb_pkg::CMP_W-1:0] fill_ext, free_ext, stop_ext, resume_ext;
  logic                      ctrl_valid;
  logic [7:0]                ctrl_byte;

  assign laps_differ = head[rrb_pkg::ADDR_W] != tail[rrb_pkg::ADDR_W];
  assign empty = head == tail;
  assign full  = laps_differ && (head[rrb_pkg::ADDR_W-1:0] == tail[rrb_pkg::ADDR_W-1:0]);

  // pointer advance; index wraps into the lap bit
  always_comb begin
    head_next = head;
    tail_next = tail;
    if (func == rrb_pkg::FUNC_RECEIVE) begin
      if (!full) begin
        head_next = head + rrb_pkg::PTR_W'(1);
      end
    end else begin
      if (!empty) begin
        tail_next = tail + rrb_pkg::PTR_W'(1);
      end
    end
  end

  // occupancy and free space after the step
  assign laps_differ_next = head_next[rrb_pkg::ADDR_W] != tail_next[rrb_pkg::ADDR_W];
  assign fill_next  = head_next - tail_next;
  assign fill_ext   = rrb_pkg::CMP_W'(fill_next);
  assign free_ext   = rrb_pkg::CMP_W'(rrb_pkg::DEPTH) - fill_ext;
  assign stop_ext   = rrb_pkg::CMP_W'(cfg.stop_free_below);
  assign resume_ext = rrb_pkg::CMP_W'(cfg.resume_free_above);

  // flow control decision
  always_comb begin
    held_next  = held;
    ctrl_valid = 1'b0;
    ctrl_byte  = 8'h00;
    if (func == rrb_pkg::FUNC_RECEIVE) begin
      if (!held && cfg.flow_enable && laps_differ_next && (free_ext < stop_ext)) begin
        held_next  = 1'b1;
        ctrl_valid = 1'b1;
        ctrl_byte  = rrb_pkg::XOFF_CHAR;
      end
    end else begin
      if (held && (!laps_differ_next || (free_ext > resume_ext))) begin
        held_next  = 1'b0;
        ctrl_valid = 1'b1;
        ctrl_byte  = rrb_pkg::XON_CHAR;
      end
    end
  end

  assign result.ctrl_valid = ctrl_valid;
  assign result.ctrl_byte  = ctrl_byte;
  assign result.read_valid = (func == rrb_pkg::FUNC_READ) && !empty;
  assign result.overflow   = (func == rrb_pkg::FUNC_RECEIVE) && full;
  assign result.fill       = fill_ext;
  assign result.stopped    = held_next;

  // buffer accesses for the accepted word
  assign mem_req.wr_en   = accept && (func == rrb_pkg::FUNC_RECEIVE) && !full;
  assign mem_req.wr_addr = head[rrb_pkg::ADDR_W-1:0];
  assign mem_req.wr_data = rx_byte;
  assign mem_req.rd_en   = accept && result.read_valid;
  assign mem_req.rd_addr = tail[rrb_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      held <= 1'b0;
    end else if (accept) begin
      head <= head_next;
      tail <= tail_next;
      held <= held_next;
    end
  end

endmodule

[design/rx_ring_buffer_xon_xoff_top.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Serial receive ring buffer with XON/XOFF flow control.
// Input channel (in_valid/in_ready): func 0 stores rx_byte at the head,
// func 1 pops the oldest byte. Every input word yields one result word
// on the output channel (out_valid/out_ready): popped byte, flow control
// character to transmit (XOFF 0x13 / XON 0x11), overflow flag, fill level
// and the stopped flag.
// Results are registered: an accepted word's result is valid in the
// next cycle. One word per cycle is sustained while results are taken;
// the byte store is a single RAM with one write and one registered read
// port, pointer update and threshold compare settle in the accept cycle.
// A stalled receiver holds the result register and in_ready is low; a new
// input word is taken when no result is pending or as the pending one is taken.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready
// and should be written only while the block is idle.
// Reset clears pointers, the stopped flag and the output valid flag, and
// loads flow_enable 0, stop threshold 128, resume threshold 256. Buffer
// contents are not cleared; no clearing pass is needed.
module rx_ring_buffer_xon_xoff_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         func,
  input  logic [7:0]                   rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         read_valid,
  output logic [7:0]                   read_byte,
  output logic                         ctrl_valid,
  output logic [7:0]                   ctrl_byte,
  output logic                         overflow,
  output logic [rrb_pkg::FIELD_W-1:0]  fill_level,
  output logic                         stopped_flag,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [rrb_pkg::FIELD_W-1:0]  cfg_data
);

  rrb_pkg::rrb_cfg_t     cfg;
  rrb_pkg::rrb_mem_req_t mem_req;
  rrb_pkg::rrb_result_t  result;
  rrb_pkg::rrb_result_t  res;
  logic                  accept;
  logic [7:0]            ram_q;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flow_enable       <= 1'b0;
      cfg.stop_free_below   <= rrb_pkg::STOP_RESET;
      cfg.resume_free_above <= rrb_pkg::RESUME_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rrb_pkg::CFG_FLOW_ENABLE:  cfg.flow_enable       <= cfg_data[0];
        rrb_pkg::CFG_STOP_BELOW:   cfg.stop_free_below   <= cfg_data;
        rrb_pkg::CFG_RESUME_ABOVE: cfg.resume_free_above <= cfg_data;
        default: ;
      endcase
    end
  end

  rrb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .func    (func),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .mem_req (mem_req),
    .result  (result)
  );

  rrb_ram #(
    .DATA_W (8),
    .ADDR_W (rrb_pkg::ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (ram_q)
  );

  // output register; popped byte comes straight from the RAM read register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= result;
    end
  end

  assign read_valid   = res.read_valid;
  assign read_byte    = res.read_valid ? ram_q : 8'h00;
  assign ctrl_valid   = res.ctrl_valid;
  assign ctrl_byte    = res.ctrl_byte;
  assign overflow     = res.overflow;
  assign fill_level   = res.fill[rrb_pkg::FIELD_W-1:0];
  assign stopped_flag = res.stopped;

  // checks
  `RRB_ASSERT(a_accept_gives_result, (in_valid && in_ready) |=> out_valid,
              "accepted word produced no result")
  `RRB_ASSERT(a_overflow_when_full,
              (out_valid && res.overflow) |-> (res.fill == rrb_pkg::CMP_W'(rrb_pkg::DEPTH)),
              "overflow reported while buffer not full")
  `RRB_ASSERT_NEVER(a_pop_leaves_room,
                    out_valid && res.read_valid && (res.fill == rrb_pkg::CMP_W'(rrb_pkg::DEPTH)),
                    "buffer still full after a pop")
  `RRB_ASSERT(a_xoff_sets_stop,
              (out_valid && res.ctrl_valid && (res.ctrl_byte == rrb_pkg::XOFF_CHAR))
                |-> (res.stopped && !res.read_valid),
              "XOFF without stopped state")

endmodule
